/* rtl/core/tilt_moving_average_level_top_defines.svh */
// Assertion macros for the tilt moving average level block
`ifndef TILT_MOVING_AVERAGE_LEVEL_TOP_DEFINES_SVH
`define TILT_MOVING_AVERAGE_LEVEL_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tma assertion failed");

// next-cycle implication, checked out of reset
`define TMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tma assertion failed");

`endif

/* rtl/core/tma_pkg.sv */
// Shared constants, types and register codes for the tilt moving average level block
package tma_pkg;

    localparam int WindowLength = 10;

    localparam int SAMPLE_W = 8;
    localparam int LEVEL_W  = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam int POS_W  = (WindowLength > 1) ? $clog2(WindowLength) : 1;
    localparam int SUM_W  = $clog2(255 * WindowLength + 1);
    localparam int DIV_L  = $clog2(WindowLength);
    localparam int SHIFT  = SUM_W + DIV_L;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int unsigned RECIP = ((1 << SHIFT) + WindowLength - 1) / WindowLength;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LIMIT   = 1'd1;

    localparam logic [CFG_W-1:0] CENTER_RESET = 8'd130;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 8'd50;

    typedef struct packed {
        logic load;
        logic advance;
    } lane_ctl_t;

endpackage

/* rtl/core/tma_lane.sv */
// One axis lane: sample window, running sum and window mean
module tma_lane (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tma_pkg::lane_ctl_t               ctl,
    input  logic [tma_pkg::POS_W-1:0]        write_pos,
    input  logic [tma_pkg::SAMPLE_W-1:0]     sample,
    output logic [tma_pkg::SAMPLE_W-1:0]     mean
);

    logic [tma_pkg::SAMPLE_W-1:0] window_reg [tma_pkg::WindowLength];
    logic [tma_pkg::SUM_W-1:0]    sum_reg;
    logic [tma_pkg::SUM_W-1:0]    sum_next;
    logic [tma_pkg::PROD_W-1:0]   prod;
    logic [tma_pkg::SAMPLE_W-1:0] mean_reg;

    assign sum_next = sum_reg - tma_pkg::SUM_W'(window_reg[write_pos])
                    + tma_pkg::SUM_W'(sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tma_pkg::WindowLength; i++) begin
                window_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (ctl.load) begin
            window_reg[write_pos] <= sample;
            sum_reg               <= sum_next;
        end
    end

    // divide by window length: reciprocal multiply, exact over the sum range
    assign prod = tma_pkg::PROD_W'(sum_reg) * tma_pkg::PROD_W'(tma_pkg::RECIP);

    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            mean_reg <= prod[tma_pkg::SHIFT +: tma_pkg::SAMPLE_W];
        end
    end

    assign mean = mean_reg;

endmodule

/* rtl/core/tma_merge.sv */
// Merging stage: centre, rectify and clamp both lane means into the result register
module tma_merge (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [tma_pkg::SAMPLE_W-1:0]  x_mean,
    input  logic [tma_pkg::SAMPLE_W-1:0]  y_mean,
    input  logic [tma_pkg::CFG_W-1:0]     center,
    input  logic [tma_pkg::CFG_W-1:0]     limit,
    output logic [tma_pkg::LEVEL_W-1:0]   x_level,
    output logic [tma_pkg::LEVEL_W-1:0]   y_level
);

    logic [tma_pkg::LEVEL_W-1:0] x_dev, y_dev;
    logic [tma_pkg::LEVEL_W-1:0] x_level_next, y_level_next;
    logic [tma_pkg::LEVEL_W-1:0] x_level_reg, y_level_reg;

    always_comb begin
        x_dev = (x_mean >= center) ? (x_mean - center) : (center - x_mean);
        y_dev = (y_mean >= center) ? (y_mean - center) : (center - y_mean);
        x_level_next = (x_dev > limit) ? limit : x_dev;
        y_level_next = (y_dev > limit) ? limit : y_dev;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_level_reg <= x_level_next;
            y_level_reg <= y_level_next;
        end
    end

    assign x_level = x_level_reg;
    assign y_level = y_level_reg;

endmodule

/* rtl/core/tilt_moving_average_level_top.sv */
// Tilt moving average level: two-axis boxcar mean, centred, rectified and clamped
//
// Input channel s_*: one X/Y sample pair per transaction (s_valid/s_ready).
// Result channel m_*: one X/Y level pair per input transaction (m_valid/m_ready).
// Config port: cfg_wr_en writes cfg_wr_data[7:0] to register cfg_index at the
// clock edge (0 = centre offset, 1 = level limit); write only while idle.
// Pipeline: lane update (window and running sum), lane mean by reciprocal
// multiply, then centre/clamp into the output register.
// m_valid rises once the transaction has passed the lane, mean and output registers
// in turn. Throughput: one transaction per cycle while m_ready holds high, set by
// the three-stage pipeline with both axis lanes working in parallel.
// A stalled receiver holds the result; stages behind it keep filling and
// s_ready drops only once every stage holds a transaction.
// Reset (aresetn low, synchronous) clears both windows, the running sums, the
// write position and the pipeline, and loads offset 130 and limit 50. No
// clearing pass is needed; s_ready is high in the first cycle after reset.
`include "tilt_moving_average_level_top_defines.svh"

module tilt_moving_average_level_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tma_pkg::SAMPLE_W-1:0]    s_x_sample,
    input  logic [tma_pkg::SAMPLE_W-1:0]    s_y_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tma_pkg::LEVEL_W-1:0]     m_x_level,
    output logic [tma_pkg::LEVEL_W-1:0]     m_y_level,
    input  logic                            cfg_wr_en,
    input  logic [tma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tma_pkg::CFG_W-1:0]       cfg_wr_data
);

    localparam logic [tma_pkg::POS_W-1:0] LAST_POS = tma_pkg::POS_W'(tma_pkg::WindowLength - 1);

    logic [tma_pkg::CFG_W-1:0] center_reg, limit_reg;
    logic [tma_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      v1_reg, v2_reg, out_valid_reg;
    logic                      en1, en2, en3, accept;
    tma_pkg::lane_ctl_t        ctl;
    logic [tma_pkg::SAMPLE_W-1:0] x_mean, y_mean;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= tma_pkg::CENTER_RESET;
            limit_reg  <= tma_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tma_pkg::REG_CENTER_OFFSET: center_reg <= cfg_wr_data;
                tma_pkg::REG_LEVEL_LIMIT:   limit_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // stall chain
    assign en3    = !out_valid_reg || m_ready;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign accept = s_valid && en1;

    assign ctl.load    = accept;
    assign ctl.advance = en2 && v1_reg;

    assign pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                pos_reg <= pos_next;
            end
            if (en1) begin
                v1_reg <= accept;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    tma_lane u_lane_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .write_pos (pos_reg),
        .sample    (s_x_sample),
        .mean      (x_mean)
    );

    tma_lane u_lane_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .write_pos (pos_reg),
        .sample    (s_y_sample),
        .mean      (y_mean)
    );

    tma_merge u_merge (
        .aclk    (aclk),
        .load    (en3 && v2_reg),
        .x_mean  (x_mean),
        .y_mean  (y_mean),
        .center  (center_reg),
        .limit   (limit_reg),
        .x_level (m_x_level),
        .y_level (m_y_level)
    );

    assign s_ready = en1;
    assign m_valid = out_valid_reg;

    `TMA_ASSERT_NOW(a_pos_in_window, 1'b1, pos_reg <= LAST_POS)
    `TMA_ASSERT_NOW(a_ready_when_s1_empty, !v1_reg, s_ready)
    `TMA_ASSERT_NEXT(a_accept_fills_s1, accept, v1_reg)
    `TMA_ASSERT_NEXT(a_s2_drains_to_out, v2_reg && en3, m_valid)
    `TMA_ASSERT_NEXT(a_pos_steps, accept && pos_reg != LAST_POS, pos_reg == $past(pos_reg) + 1'b1)

endmodule

/* tb/tma_level_checker.sv */
// Checker for the tilt moving average level block: predicts every level pair and compares it
`timescale 1ns / 100ps

module tma_level_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [tma_pkg::SAMPLE_W-1:0]    s_x_sample,
    input  logic [tma_pkg::SAMPLE_W-1:0]    s_y_sample,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [tma_pkg::LEVEL_W-1:0]     m_x_level,
    input  logic [tma_pkg::LEVEL_W-1:0]     m_y_level,
    input  logic                            cfg_wr_en,
    input  logic [tma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tma_pkg::CFG_W-1:0]       cfg_wr_data,
    output int                              fail_count,
    output int                              pending
);

    typedef struct packed {
        logic [tma_pkg::LEVEL_W-1:0] x_level;
        logic [tma_pkg::LEVEL_W-1:0] y_level;
    } level_pair_t;

    logic [tma_pkg::SAMPLE_W-1:0] x_hist [tma_pkg::WindowLength];
    logic [tma_pkg::SAMPLE_W-1:0] y_hist [tma_pkg::WindowLength];
    logic [tma_pkg::POS_W-1:0]    slot;
    logic [tma_pkg::SUM_W-1:0]    x_sum;
    logic [tma_pkg::SUM_W-1:0]    y_sum;
    logic [tma_pkg::CFG_W-1:0]    centre;
    logic [tma_pkg::CFG_W-1:0]    level_cap;
    level_pair_t                  level_q[$];
    int                           errors = 0;

    // truncated window mean, rectified about the centre and clamped
    function automatic logic [tma_pkg::LEVEL_W-1:0] tilt_of(
        input logic [tma_pkg::SUM_W-1:0] sum,
        input logic [tma_pkg::CFG_W-1:0] c,
        input logic [tma_pkg::CFG_W-1:0] cap);
        int mean;
        int dev;
        mean = int'(sum) / tma_pkg::WindowLength;
        dev  = (mean >= int'(c)) ? mean - int'(c) : int'(c) - mean;
        if (dev > int'(cap)) dev = int'(cap);
        return dev[tma_pkg::LEVEL_W-1:0];
    endfunction

    always @(posedge aclk) begin
        level_pair_t got;
        level_pair_t want;
        if (!aresetn) begin
            for (int i = 0; i < tma_pkg::WindowLength; i++) begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            slot      = '0;
            x_sum     = '0;
            y_sum     = '0;
            centre    = tma_pkg::CENTER_RESET;
            level_cap = tma_pkg::LIMIT_RESET;
            level_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tma_pkg::REG_CENTER_OFFSET: centre = cfg_wr_data;
                    tma_pkg::REG_LEVEL_LIMIT: level_cap = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.x_level = m_x_level;
                got.y_level = m_y_level;
                if (level_q.size() == 0) begin
                    errors++;
                    $display("%0t: result transaction with nothing expected, x_level %0d y_level %0d",
                             $time, got.x_level, got.y_level);
                end else begin
                    want = level_q.pop_front();
                    if (got.x_level !== want.x_level) begin
                        errors++;
                        $display("%0t: x_level expected %0d actual %0d",
                                 $time, want.x_level, got.x_level);
                    end
                    if (got.y_level !== want.y_level) begin
                        errors++;
                        $display("%0t: y_level expected %0d actual %0d",
                                 $time, want.y_level, got.y_level);
                    end
                end
            end
            if (s_valid && s_ready) begin
                x_sum = x_sum - tma_pkg::SUM_W'(x_hist[slot])
                      + tma_pkg::SUM_W'(s_x_sample);
                y_sum = y_sum - tma_pkg::SUM_W'(y_hist[slot])
                      + tma_pkg::SUM_W'(s_y_sample);
                x_hist[slot] = s_x_sample;
                y_hist[slot] = s_y_sample;
                slot = (slot == tma_pkg::POS_W'(tma_pkg::WindowLength - 1)) ? '0
                                                                             : slot + 1'b1;
                want.x_level = tilt_of(x_sum, centre, level_cap);
                want.y_level = tilt_of(y_sum, centre, level_cap);
                level_q.push_back(want);
            end
        end
        fail_count <= errors;
        pending    <= level_q.size();
    end

endmodule

/* tb/tb_tilt_moving_average_level_top.sv */
// Testbench top for the tilt moving average level block: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_tilt_moving_average_level_top;

    localparam int LONG_HOLD  = 80;
    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES     = 16;
    localparam int PHASE_LEN  = 100;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [tma_pkg::SAMPLE_W-1:0]  s_x_sample  = '0;
    logic [tma_pkg::SAMPLE_W-1:0]  s_y_sample  = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [tma_pkg::LEVEL_W-1:0]   m_x_level;
    logic [tma_pkg::LEVEL_W-1:0]   m_y_level;
    logic                          cfg_wr_en   = 1'b0;
    logic [tma_pkg::CFG_IDX_W-1:0] cfg_index   = tma_pkg::REG_CENTER_OFFSET;
    logic [tma_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    int                            fail_count;
    int                            pending;
    bit                            no_idle     = 1'b0;
    bit                            hold_req    = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tilt_moving_average_level_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_x_sample  (s_x_sample),
        .s_y_sample  (s_y_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_x_level   (m_x_level),
        .m_y_level   (m_y_level),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    tma_level_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_x_sample  (s_x_sample),
        .s_y_sample  (s_y_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_x_level   (m_x_level),
        .m_y_level   (m_y_level),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    function automatic int gap_draw();
        return no_idle ? 0 : int'($urandom_range(0, 6));
    endfunction

    // sample scattered about the centre so that levels land below the clamp too
    function automatic logic [tma_pkg::SAMPLE_W-1:0] sample_near(
        input logic [tma_pkg::CFG_W-1:0] c,
        input int spread);
        int v;
        v = int'(c) - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[tma_pkg::SAMPLE_W-1:0];
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_pair(input logic [tma_pkg::SAMPLE_W-1:0] x,
                             input logic [tma_pkg::SAMPLE_W-1:0] y,
                             input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_x_sample <= x;
        s_y_sample <= y;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic set_levels(input logic [tma_pkg::CFG_W-1:0] c,
                              input logic [tma_pkg::CFG_W-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= tma_pkg::REG_CENTER_OFFSET;
        cfg_wr_data <= c;
        @(negedge aclk);
        cfg_index   <= tma_pkg::REG_LEVEL_LIMIT;
        cfg_wr_data <= cap;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // result side: random stall per transaction, one long hold-off on request
    initial begin
        int gap;
        do @(negedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                gap = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                gap = gap_draw();
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tilt_moving_average_level_top: mismatch");
        $finish;
    end

    initial begin
        logic [tma_pkg::CFG_W-1:0]    centre;
        logic [tma_pkg::CFG_W-1:0]    cap;
        logic [tma_pkg::SAMPLE_W-1:0] x;
        logic [tma_pkg::SAMPLE_W-1:0] y;
        int                           spread;
        int                           gap;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings; partly filled window, then a full one and the wrap
        send_pair(8'd0, 8'd0, gap_draw());
        send_pair(8'd255, 8'd255, gap_draw());
        send_pair(8'd255, 8'd0, gap_draw());
        send_pair(8'd0, 8'd255, gap_draw());
        repeat (11) send_pair(8'd255, 8'd255, gap_draw());
        for (int k = 0; k < tma_pkg::SAMPLE_W; k++)
            send_pair(tma_pkg::SAMPLE_W'(1) << k, ~(tma_pkg::SAMPLE_W'(1) << k),
                      gap_draw());
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin centre = 8'd0;   cap = 8'd255; end
                1: begin centre = 8'd255; cap = 8'd0;   end
                2: begin centre = 8'd255; cap = 8'd255; end
                3: begin centre = 8'd0;   cap = 8'd0;   end
                default: begin
                    centre = tma_pkg::CFG_W'($urandom_range(0, 255));
                    cap = ($urandom_range(0, 1) == 0)
                        ? tma_pkg::CFG_W'($urandom_range(0, 60))
                        : tma_pkg::CFG_W'($urandom_range(0, 255));
                end
            endcase
            set_levels(centre, cap);
            no_idle = (phase % 4 == 2);
            spread  = ($urandom_range(0, 3) == 0) ? 127 : int'($urandom_range(1, 40));

            // fill the pipeline against a held-off receiver
            if (phase == 6) hold_req = 1'b1;

            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    x = tma_pkg::SAMPLE_W'($urandom_range(0, 255));
                    y = tma_pkg::SAMPLE_W'($urandom_range(0, 255));
                end else begin
                    x = sample_near(centre, spread);
                    y = sample_near(centre, spread);
                end
                gap = (phase == 6 && n < 30) ? 0 : gap_draw();
                send_pair(x, y, gap);
            end
            drain();
        end

        no_idle = 1'b0;
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("tilt_moving_average_level_top: match");
        else
            $display("tilt_moving_average_level_top: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tma_pkg.sv
rtl/core/tma_lane.sv
rtl/core/tma_merge.sv
rtl/core/tilt_moving_average_level_top.sv
tb/tma_level_checker.sv
tb/tb_tilt_moving_average_level_top.sv
